>>> sv/rbsi_pkg.sv
// Shared constants, types and functions for the ray/box slab intersection block.
package rbsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int NUM_W = 33;
	localparam int QDEPTH_DEF = 4;

	localparam logic [2:0] NORMAL_NONE = 3'd0;
	localparam logic [2:0] NORMAL_POS_X = 3'd1;
	localparam logic [2:0] NORMAL_NEG_X = 3'd2;
	localparam logic [2:0] NORMAL_POS_Y = 3'd3;
	localparam logic [2:0] NORMAL_NEG_Y = 3'd4;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// One item as it travels through the front pipeline.
	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] box_left;
		logic signed [31:0] box_top;
		logic signed [31:0] box_right;
		logic signed [31:0] box_bottom;
	} ray_item_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic hit;
		logic signed [31:0] entry_time;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic [2:0] normal_code;
	} hit_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7FFF_FFFF) begin
			r = S32_MAX;
		end else if (v < -66'sh0_8000_0000) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/ray_box_slab_intersect.sv
// Ray against axis-aligned box slab test, top level.
// Throughput: one ray per cycle unless full; four bit-per-stage dividers set the latency.
// Back pressure stalls the back part; the front pipeline stops only when the queue could fill.
// Reset: arst_n clears all valid flags, queue pointers and count; data registers are not reset.
module ray_box_slab_intersect import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] box_left,
	input  logic signed [31:0] box_top,
	input  logic signed [31:0] box_right,
	input  logic signed [31:0] box_bottom,
	output logic empty,
	input  logic pop,
	output logic hit,
	output logic signed [31:0] entry_time,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y,
	output logic [2:0] normal_code
);
	localparam int QD = QDEPTH_DEF;

	ray_item_t item;
	hit_item_t fr_res, q_out;
	logic fr_vld, q_ne, bk_rdy, bk_vld, fr_adv, q_rd, q_wr;
	logic [$clog2(QD+1)-1:0] q_cnt;

	assign item = '{origin_x, origin_y, dir_x, dir_y, box_left, box_top, box_right, box_bottom};

	// The front advances while the queue has room for the item leaving it.
	assign fr_adv = (q_cnt != ($clog2(QD+1))'(QD)) || q_rd;
	assign full = !fr_adv;
	assign q_wr = fr_adv && fr_vld;
	assign q_rd = q_ne && bk_rdy;

	rbsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .adv(fr_adv), .in_valid(push && fr_adv), .item,
		.out_valid(fr_vld), .result(fr_res)
	);

	rbsi_fifo #(.DEPTH(QD)) u_fifo (
		.clk, .arst_n, .wr(q_wr), .wdata(fr_res), .rd(q_rd), .rdata(q_out),
		.nempty(q_ne), .count(q_cnt)
	);

	rbsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .in_valid(q_ne), .item(q_out), .in_ready(bk_rdy),
		.out_valid(bk_vld), .out_pop(pop), .hit, .entry_time, .contact_x,
		.contact_y, .normal_code
	);

	assign empty = !bk_vld;
endmodule

>>> sv/rbsi_div.sv
// Pipelined signed divider: one quotient bit per stage, truncating toward zero, saturated.
module rbsi_div import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic adv,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [31:0] den,
	output logic signed [31:0] quo
);
	// Dividend magnitude width: 33-bit numerator shifted by FRAC_BITS.
	localparam int NW = NUM_W + FRAC_BITS;
	localparam int ST = NW;

	logic [NW-1:0] rem_s1 [ST+1];
	logic [NW-1:0] qb_s1 [ST+1];
	logic [31:0] dmag_s1 [ST+1];
	logic neg_s1 [ST+1];
	logic zero_s1 [ST+1];
	logic nneg_s1 [ST+1];

	logic [NUM_W-1:0] nmag;
	assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1[0] <= '0;
			qb_s1[0] <= {nmag, {FRAC_BITS{1'b0}}};
			dmag_s1[0] <= den[31] ? 32'(-den) : 32'(den);
			neg_s1[0] <= num[NUM_W-1] ^ den[31];
			zero_s1[0] <= (den == '0);
			nneg_s1[0] <= num[NUM_W-1];
		end
	end

	for (genvar i = 0; i < ST; i++) begin : g_stage
		logic [NW:0] trial;
		logic [NW-1:0] shifted;
		assign shifted = {rem_s1[i][NW-2:0], qb_s1[i][NW-1]};
		assign trial = {1'b0, shifted} - {{(NW-31){1'b0}}, dmag_s1[i]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s1[i+1] <= trial[NW] ? shifted : trial[NW-1:0];
				qb_s1[i+1] <= {qb_s1[i][NW-2:0], ~trial[NW]};
				dmag_s1[i+1] <= dmag_s1[i];
				neg_s1[i+1] <= neg_s1[i];
				zero_s1[i+1] <= zero_s1[i];
				nneg_s1[i+1] <= nneg_s1[i];
			end
		end
	end

	logic signed [65:0] sq;
	always_comb begin
		sq = neg_s1[ST] ? -$signed({{(66-NW){1'b0}}, qb_s1[ST]})
			: $signed({{(66-NW){1'b0}}, qb_s1[ST]});
		if (zero_s1[ST]) begin
			quo = nneg_s1[ST] ? S32_MIN : S32_MAX;
		end else begin
			quo = sat32(sq);
		end
	end
endmodule

>>> sv/rbsi_front.sv
// Front part: slab times through four dividers, ordering, overlap test and normal code.
module rbsi_front import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  ray_item_t item,
	output logic out_valid,
	output hit_item_t result
);
	localparam int LAT = NUM_W + FRAC_BITS + 1;

	logic signed [NUM_W-1:0] nl, nr, nt, nb;
	assign nl = NUM_W'(item.box_left) - NUM_W'(item.origin_x);
	assign nr = NUM_W'(item.box_right) - NUM_W'(item.origin_x);
	assign nt = NUM_W'(item.box_top) - NUM_W'(item.origin_y);
	assign nb = NUM_W'(item.box_bottom) - NUM_W'(item.origin_y);

	logic signed [31:0] tl, tr, tt, tb;
	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_dl (.clk, .adv, .num(nl), .den(item.dir_x), .quo(tl));
	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_dr (.clk, .adv, .num(nr), .den(item.dir_x), .quo(tr));
	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_dt (.clk, .adv, .num(nt), .den(item.dir_y), .quo(tt));
	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_db (.clk, .adv, .num(nb), .den(item.dir_y), .quo(tb));

	// Valid bits and ray data ride beside the dividers.
	logic vld_q [LAT];
	ray_item_t ray_q [LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ray_q[0] <= item;
			for (int i = 1; i < LAT; i++) ray_q[i] <= ray_q[i-1];
		end
	end

	ray_item_t rd;
	logic signed [31:0] nx, fx, ny, fy, tn, tf;
	logic hit;
	logic [2:0] code;
	always_comb begin
		rd = ray_q[LAT-1];
		nx = (tl > tr) ? tr : tl;
		fx = (tl > tr) ? tl : tr;
		ny = (tt > tb) ? tb : tt;
		fy = (tt > tb) ? tt : tb;
		tn = (nx > ny) ? nx : ny;
		tf = (fx < fy) ? fx : fy;
		hit = !(nx > fy || ny > fx) && !tf[31];
		if (nx > ny) begin
			code = rd.dir_x[31] ? NORMAL_POS_X : NORMAL_NEG_X;
		end else if (nx < ny) begin
			code = rd.dir_y[31] ? NORMAL_POS_Y : NORMAL_NEG_Y;
		end else begin
			code = NORMAL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			result.hit <= hit;
			result.entry_time <= hit ? tn : '0;
			result.origin_x <= rd.origin_x;
			result.origin_y <= rd.origin_y;
			result.dir_x <= rd.dir_x;
			result.dir_y <= rd.dir_y;
			result.normal_code <= hit ? code : NORMAL_NONE;
		end
	end
endmodule

>>> sv/rbsi_fifo.sv
// Short queue between the front and back parts.
module rbsi_fifo import rbsi_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  hit_item_t wdata,
	input  logic rd,
	output hit_item_t rdata,
	output logic nempty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	hit_item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
	assign rdata = mem_q[rp_q];
	assign nempty = (count != '0);
endmodule

>>> sv/rbsi_back.sv
// Back part: contact point multiply, shift, add and saturate, with an output register.
module rbsi_back import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  hit_item_t item,
	output logic in_ready,
	output logic out_valid,
	input  logic out_pop,
	output logic hit,
	output logic signed [31:0] entry_time,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y,
	output logic [2:0] normal_code
);
	logic adv;
	logic v_s1;
	logic signed [63:0] px_s1, py_s1;
	hit_item_t it_s1;
	assign adv = !out_valid || out_pop;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	logic signed [65:0] sx, sy;
	assign sx = 66'(px_s1 >>> FRAC_BITS) + 66'(it_s1.origin_x);
	assign sy = 66'(py_s1 >>> FRAC_BITS) + 66'(it_s1.origin_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= item.dir_x * item.entry_time;
			py_s1 <= item.dir_y * item.entry_time;
			it_s1 <= item;
			hit <= it_s1.hit;
			entry_time <= it_s1.entry_time;
			normal_code <= it_s1.normal_code;
			contact_x <= it_s1.hit ? sat32(sx) : '0;
			contact_y <= it_s1.hit ? sat32(sy) : '0;
		end
	end
endmodule
